>>> rtl/bgc_pkg.sv
// ============================================================================
// Button gesture classifier package
// Shared types, codes and constants of the button gesture classifier.
// ============================================================================
`default_nettype none

package bgc_pkg;

    localparam int MS_W = 14;
    localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};
    localparam logic [MS_W-1:0] LONG_PRESS_RESET = 14'd300;
    localparam logic [MS_W-1:0] DOUBLE_CLICK_RESET = 14'd300;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef enum logic [0:0] {
        REG_LONG_PRESS   = 1'b0,
        REG_DOUBLE_CLICK = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_PRESS   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_OTHER   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_PREVIOUS = 3'd0,
        ACT_NEXT     = 3'd1,
        ACT_START    = 3'd2,
        ACT_SUSPEND  = 3'd3,
        ACT_CONTINUE = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HELD   = 2'd1,
        PH_WINDOW = 2'd2
    } phase_t;

    typedef struct packed {
        logic    valid;
        action_t action;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/bgc_core.sv
// ============================================================================
// Button gesture classifier core
// Phase FSM and millisecond counter; one item per cycle while accept is high.
// ============================================================================
`default_nettype none

module bgc_core
    import bgc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire op_t             op,
    input  wire logic            started,
    input  wire logic            suspended,
    input  wire logic [MS_W-1:0] long_press_ms,
    input  wire logic [MS_W-1:0] double_click_ms,
    output result_t              res
);

    phase_t          phase_reg;
    phase_t          phase_next;
    logic [MS_W-1:0] elapsed_reg;
    logic [MS_W-1:0] elapsed_next;
    logic [MS_W-1:0] elapsed_inc;
    logic            expire;
    logic            long_hold;

    assign elapsed_inc = (elapsed_reg == MS_MAX) ? elapsed_reg : elapsed_reg + 14'd1;
    assign expire      = (elapsed_inc >= double_click_ms);
    assign long_hold   = (elapsed_reg > long_press_ms);

    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        if (accept)
        begin
            case (op)
                OP_TICK:
                begin
                    case (phase_reg)
                        PH_HELD:
                        begin
                            elapsed_next = elapsed_inc;
                        end
                        PH_WINDOW:
                        begin
                            if (expire)
                            begin
                                phase_next   = PH_IDLE;
                                elapsed_next = '0;
                            end
                            else
                            begin
                                elapsed_next = elapsed_inc;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_PRESS:
                begin
                    case (phase_reg)
                        PH_WINDOW:
                        begin
                            phase_next   = PH_IDLE;
                            elapsed_next = '0;
                        end
                        PH_HELD:
                        begin
                        end
                        default:
                        begin
                            phase_next   = PH_HELD;
                            elapsed_next = '0;
                        end
                    endcase
                end
                OP_RELEASE:
                begin
                    case (phase_reg)
                        PH_HELD:
                        begin
                            phase_next   = long_hold ? PH_IDLE : PH_WINDOW;
                            elapsed_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res.valid  = 1'b0;
        res.action = ACT_PREVIOUS;
        if (accept)
        begin
            case (op)
                OP_TICK:
                begin
                    if (phase_reg == PH_WINDOW && expire)
                    begin
                        res.valid = 1'b1;
                        if (!started)
                        begin
                            res.action = ACT_START;
                        end
                        else if (!suspended)
                        begin
                            res.action = ACT_SUSPEND;
                        end
                        else
                        begin
                            res.action = ACT_CONTINUE;
                        end
                    end
                end
                OP_PRESS:
                begin
                    if (phase_reg == PH_WINDOW)
                    begin
                        res.valid  = 1'b1;
                        res.action = ACT_NEXT;
                    end
                end
                OP_RELEASE:
                begin
                    if (phase_reg == PH_HELD && long_hold)
                    begin
                        res.valid  = 1'b1;
                        res.action = ACT_PREVIOUS;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/button_gesture_classifier_top.sv
// ============================================================================
// Button gesture classifier top level
// Stream input of tick and key words, stream output of actions, APB registers.
// ============================================================================
// Output: a word's result is registered and shown in the cycle after the word.
// Throughput: one input word per cycle; the output register lets a new word in
// whenever it is empty or is being taken in the same cycle.
// Reset: rst_n clears the phase, the counter and the output valid at once and
// loads both time limits with 300 ms.
`default_nettype none

module button_gesture_classifier_top
    import bgc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [0] playback_started, [1] playback_suspended
    input  wire logic [1:0]        s_tuser,   // [1:0] operation
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // [2:0] action
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    logic [MS_W-1:0] long_press_reg;
    logic [MS_W-1:0] double_click_reg;
    logic            out_valid_reg;
    action_t         action_reg;
    logic            in_accept;
    logic            cfg_write;
    reg_index_t      cfg_index;
    result_t         core_res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        case (cfg_index)
            REG_LONG_PRESS:   prdata = {{(DATA_W-MS_W){1'b0}}, long_press_reg};
            REG_DOUBLE_CLICK: prdata = {{(DATA_W-MS_W){1'b0}}, double_click_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg   <= LONG_PRESS_RESET;
            double_click_reg <= DOUBLE_CLICK_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_LONG_PRESS)
            begin
                long_press_reg <= pwdata[MS_W-1:0];
            end
            else
            begin
                double_click_reg <= pwdata[MS_W-1:0];
            end
        end
    end

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    bgc_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_accept),
        .op              (op_t'(s_tuser)),
        .started         (s_tdata[0]),
        .suspended       (s_tdata[1]),
        .long_press_ms   (long_press_reg),
        .double_click_ms (double_click_reg),
        .res             (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_res.valid)
        begin
            action_reg <= core_res.action;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, action_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        core_res.valid |=> m_tvalid)
        else $error("result of an accepted word did not reach the output");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked output");

    assert property (@(posedge clk) disable iff (!rst_n)
        core_res.valid |-> in_accept)
        else $error("result produced without an accepted word");

endmodule

`default_nettype wire
